### design/i8gemm_pkg.sv
// Shared types and constants for the int8 dot-accumulate GEMM block.
// Holds command codes, register indexes, sequencer states and the packing widths
// of the stream buses. Depends on nothing.
package i8gemm_pkg;

  // Terms taken per cycle by the MAC unit
  localparam int unsigned GROUP = 4;

  // Stream payload widths
  localparam int unsigned S_TDATA_W = 64;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned M_TUSER_W = 1;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_INNER_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS     = 2'd1;

  localparam logic [CFG_DATA_W-1:0] INNER_LENGTH_RST = 9'd256;
  localparam logic [CFG_DATA_W-1:0] NUM_COLS_RST     = 9'd256;

  // Item commands
  typedef enum logic [1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

endpackage

### design/int8_dot_accumulate_gemm.sv
// Int8 row-times-matrix multiply-accumulate (u8 A x s8 B -> s32 C), top level.
// Holds the A row and B matrix memories, the 4-lane MAC unit and its sequencer.
// Depends on i8gemm_pkg.
//
// Usage:
//   s_axis carries one item: tuser holds the command (load A, load B, compute),
//   tdata holds k_index, col_index, a_value, b_value and c_in. Loads write one
//   byte of the A row or of B and give no result. A compute item returns one
//   result on m_axis: c_in plus the dot product of the A row with column
//   col_index of B over floor(min(K, K_MAX)/4)*4 terms, wrapping at 32 bits.
//   A column at or beyond num_cols (or N_MAX) gives bad_col = 1, c_out = 0.
//   The cfg channel writes inner_length (index 0) and num_cols (index 1).
// Timing:
//   A load leaves the sequencer idle. A compute item reads one 32-bit word of each
//   memory per cycle, four byte products per word, for each of the floor(K/4)
//   groups; the products pass the psum register and the accumulator, then the
//   result is registered in the output register and the sequencer returns to
//   idle to take the next item. A bad column or K below four goes straight to
//   the drain state without reading memory. One item is in work at once.
// Reset and stall:
//   Reset sets both registers to 256 and empties the sequencer and the output
//   register; the memories are not cleared and must be loaded before use.
//   A finished result waits in the output register while loads go on; the
//   next compute item stalls at its end until the result has been taken.
module int8_dot_accumulate_gemm #(
  parameter int unsigned K_MAX = 256,
  parameter int unsigned N_MAX = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] k_index, [15:8] col_index, [23:16] a_value, [31:24] b_value, [63:32] c_in
  input  logic [i8gemm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] cmd
  input  logic [i8gemm_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  // Result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] out_col, [39:8] c_out
  output logic [i8gemm_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // [0] bad_col
  output logic [i8gemm_pkg::M_TUSER_W-1:0]  m_axis_tuser,
  // Configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [i8gemm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [i8gemm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import i8gemm_pkg::*;

  // Memory geometry: one word holds four consecutive k of one column
  localparam int unsigned GRP_N  = (K_MAX + GROUP - 1) / GROUP;
  localparam int unsigned AW     = (GRP_N > 1) ? $clog2(GRP_N) : 1;
  localparam int unsigned B_DEPTH = GRP_N * N_MAX;
  localparam int unsigned BW     = $clog2(B_DEPTH);
  localparam int unsigned GW     = $clog2(GRP_N + 1);
  localparam int unsigned WORD_W = 8 * GROUP;

  // Input item fields
  logic [7:0]  k_index;
  logic [7:0]  col_index;
  logic [7:0]  a_value;
  logic [7:0]  b_value;
  logic [31:0] c_in;
  cmd_e        cmd;

  assign k_index   = s_axis_tdata[7:0];
  assign col_index = s_axis_tdata[15:8];
  assign a_value   = s_axis_tdata[23:16];
  assign b_value   = s_axis_tdata[31:24];
  assign c_in      = s_axis_tdata[63:32];
  assign cmd       = cmd_e'(s_axis_tuser);

  // Configuration registers
  logic [CFG_DATA_W-1:0] inner_q;
  logic [CFG_DATA_W-1:0] cols_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q <= INNER_LENGTH_RST;
      cols_q  <= NUM_COLS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_INNER_LENGTH: inner_q <= cfg_data_i;
        REG_NUM_COLS:     cols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state
  state_e        state_q, state_d;
  logic [GW-1:0] grp_cnt_q, grp_cnt_d;
  logic [GW-1:0] ngrp_q, ngrp_d;
  logic [BW-1:0] b_addr_q, b_addr_d;
  logic          rd_vld_q;
  logic          ps_vld_q;
  logic          out_vld_q;

  logic          accept;
  logic          do_compute;
  logic          load_a_en;
  logic          load_b_en;
  logic          col_bad;
  logic [31:0]   klen;
  logic [GW-1:0] ngrp_new;
  logic          last_issue;
  logic          finish;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign do_compute    = accept && (cmd == CMD_COMPUTE);
  assign load_a_en     = accept && (cmd == CMD_LOAD_A) && (32'(k_index) < 32'(K_MAX));
  assign load_b_en     = accept && (cmd == CMD_LOAD_B) && (32'(k_index) < 32'(K_MAX))
                         && (32'(col_index) < 32'(N_MAX));
  assign col_bad       = (32'(col_index) >= 32'(cols_q)) || (32'(col_index) >= 32'(N_MAX));

  // Effective group count: min(K, K_MAX) / 4
  assign klen     = (32'(inner_q) < 32'(K_MAX)) ? 32'(inner_q) : 32'(K_MAX);
  assign ngrp_new = GW'(klen >> 2);

  assign last_issue = (GW'(grp_cnt_q + 1'b1) == ngrp_q);
  assign finish     = (state_q == ST_DRAIN) && !rd_vld_q && !ps_vld_q
                      && (!out_vld_q || m_axis_tready);

  always_comb begin
    state_d   = state_q;
    grp_cnt_d = grp_cnt_q;
    ngrp_d    = ngrp_q;
    b_addr_d  = b_addr_q;
    case (state_q)
      ST_IDLE: begin
        if (do_compute) begin
          grp_cnt_d = '0;
          ngrp_d    = ngrp_new;
          b_addr_d  = BW'(col_index);
          if (col_bad || (ngrp_new == '0)) begin
            state_d = ST_DRAIN;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        grp_cnt_d = GW'(grp_cnt_q + 1'b1);
        b_addr_d  = b_addr_q + BW'(N_MAX);
        if (last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      grp_cnt_q <= '0;
      ngrp_q    <= '0;
      b_addr_q  <= '0;
      rd_vld_q  <= 1'b0;
      ps_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      grp_cnt_q <= grp_cnt_d;
      ngrp_q    <= ngrp_d;
      b_addr_q  <= b_addr_d;
      rd_vld_q  <= (state_q == ST_RUN);
      ps_vld_q  <= rd_vld_q;
      if (finish) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // A row and B matrix memories, byte-lane writes, registered 32-bit reads
  logic [WORD_W-1:0] a_mem_q [GRP_N];
  logic [WORD_W-1:0] b_mem_q [B_DEPTH];
  logic [WORD_W-1:0] a_rd_q;
  logic [WORD_W-1:0] b_rd_q;
  logic [AW-1:0]     a_wr_addr;
  logic [BW-1:0]     b_wr_addr;
  logic [1:0]        lane;

  assign lane      = k_index[1:0];
  assign a_wr_addr = AW'(32'(k_index) >> 2);
  assign b_wr_addr = BW'((32'(k_index) >> 2) * 32'(N_MAX) + 32'(col_index));

  always_ff @(posedge clk_i) begin
    if (load_a_en) begin
      a_mem_q[a_wr_addr][lane*8 +: 8] <= a_value;
    end
    if (load_b_en) begin
      b_mem_q[b_wr_addr][lane*8 +: 8] <= b_value;
    end
    if (state_q == ST_RUN) begin
      a_rd_q <= a_mem_q[grp_cnt_q[AW-1:0]];
      b_rd_q <= b_mem_q[b_addr_q];
    end
  end

  // MAC unit: four u8 x s8 products summed per cycle
  logic signed [16:0] prod [GROUP];
  logic signed [18:0] psum_d;
  logic signed [18:0] psum_q;

  always_comb begin
    psum_d = '0;
    for (int i = 0; i < GROUP; i++) begin
      prod[i] = 17'($signed({1'b0, a_rd_q[i*8 +: 8]})) * 17'($signed(b_rd_q[i*8 +: 8]));
      psum_d  = psum_d + 19'(prod[i]);
    end
  end

  // Accumulator and output register
  logic [31:0] acc_q;
  logic [7:0]  col_q;
  logic        bad_q;
  logic [31:0] out_c_q;
  logic [7:0]  out_col_q;
  logic        out_bad_q;

  always_ff @(posedge clk_i) begin
    psum_q <= psum_d;
    if (do_compute) begin
      acc_q <= col_bad ? 32'd0 : c_in;
      col_q <= col_index;
      bad_q <= col_bad;
    end else if (ps_vld_q) begin
      acc_q <= acc_q + 32'(psum_q);
    end
    if (finish) begin
      out_c_q   <= acc_q;
      out_col_q <= col_q;
      out_bad_q <= bad_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_c_q, out_col_q};
  assign m_axis_tuser  = out_bad_q;

  // Checks
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!rd_vld_q && !ps_vld_q))
    else $error("item accepted while MAC pipeline busy");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (grp_cnt_q < ngrp_q))
    else $error("group counter beyond group count");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[39:8] == 32'd0))
    else $error("bad column result carries nonzero sum");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DRAIN))
    else $error("result raised outside drain");

  a_drain_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && out_vld_q && !m_axis_tready) |=> (state_q == ST_DRAIN))
    else $error("drain left while result not taken");

endmodule

### tb/int8_dot_accumulate_gemm_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for int8_dot_accumulate_gemm: a directed table, then random
// phases of A/B loads and column computes, each result checked against a predictor.
// Depends on i8gemm_pkg and the int8_dot_accumulate_gemm RTL.
module int8_dot_accumulate_gemm_tb;
  import i8gemm_pkg::*;

  localparam int unsigned K_MAX          = 256;
  localparam int unsigned N_MAX          = 256;
  localparam int unsigned HALF_PERIOD    = 4;
  localparam int unsigned SETTLE_CYCLES  = 80;    // covers a full 256-term compute
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS   = 1750;
  localparam int unsigned PHASE_ITEMS    = 175;
  localparam int unsigned NUM_DIR        = 27;
  localparam int unsigned NUM_PHASES     = 10;

  // Codes the package leaves out
  localparam logic [1:0]           CMD_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0]  col;
    logic [31:0] acc;
    logic        bad;
  } gemm_res_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    logic [1:0]             cmd;
    logic [7:0]             k;
    logic [7:0]             col;
    logic [7:0]             a;
    logic [7:0]             b;
    logic [31:0]            c_in;
    logic                   typed;
    logic [31:0]            want_acc;
    logic                   want_bad;
  } dir_row_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] k_len;
    logic [CFG_DATA_W-1:0] n_cols;
  } phase_cfg_t;

  // DUT inputs, all driven to known values from time zero
  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata   = '0;
  logic [S_TUSER_W-1:0]  s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [M_TUSER_W-1:0]  m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  int8_dot_accumulate_gemm #(
    .K_MAX(K_MAX),
    .N_MAX(N_MAX)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  // Expected results, oldest first
  gemm_res_t   pending_q[$];
  int unsigned err_cnt = 0;

  // Predictor copy of registers and memories, with written flags per entry
  logic [CFG_DATA_W-1:0] k_len_reg  = INNER_LENGTH_RST;
  logic [CFG_DATA_W-1:0] n_cols_reg = NUM_COLS_RST;
  logic [7:0]            a_row [K_MAX];
  logic signed [7:0]     b_mat [K_MAX][N_MAX];
  bit                    a_wr  [K_MAX];
  bit                    b_wr  [K_MAX][N_MAX];

  // Terms summed: K clamped to K_MAX, rounded down to whole groups
  function automatic int unsigned terms_used();
    int unsigned kk;
    kk = (k_len_reg > K_MAX) ? K_MAX : k_len_reg;
    return (kk / GROUP) * GROUP;
  endfunction

  // True when every operand a compute on this column reads has been written
  function automatic bit column_loaded(logic [7:0] col);
    int unsigned nt;
    nt = terms_used();
    for (int unsigned k = 0; k < nt; k++)
      if (!a_wr[k] || !b_wr[k][col]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [31:0] column_dot(logic [7:0] col, logic [31:0] acc);
    int unsigned nt;
    nt = terms_used();
    for (int unsigned k = 0; k < nt; k++)
      acc = acc + 32'(int'(a_row[k]) * int'(b_mat[k][col]));
    return acc;
  endfunction

  // Applies one accepted item to the predictor state; compute gives one result
  function automatic void predict_item(input logic [1:0] cmd, input logic [7:0] k,
                                       input logic [7:0] col, input logic [7:0] a,
                                       input logic [7:0] b, input logic [31:0] c_in,
                                       output bit has_res, output gemm_res_t res);
    has_res = 1'b0;
    res     = '0;
    case (cmd)
      CMD_LOAD_A: begin
        a_row[k] = a;
        a_wr[k]  = 1'b1;
      end
      CMD_LOAD_B: begin
        b_mat[k][col] = b;
        b_wr[k][col]  = 1'b1;
      end
      CMD_COMPUTE: begin
        has_res = 1'b1;
        res.col = col;
        if (col >= n_cols_reg) begin
          res.acc = '0;
          res.bad = 1'b1;
        end else begin
          res.acc = column_dot(col, c_in);
          res.bad = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] pick_acc();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Sender: bursts of random length separated by random gaps
  int unsigned burst_left = 0;

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] k, input logic [7:0] col,
                           input logic [7:0] a, input logic [7:0] b, input logic [31:0] c_in,
                           input bit typed, input logic [31:0] want_acc, input bit want_bad);
    int unsigned gap;
    bit          has_res;
    gemm_res_t   res;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap        = 0;
        burst_left = $urandom_range(20, 60);
      end else begin
        gap        = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 16);
      end
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {c_in, b, a, col, k};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    burst_left--;
    predict_item(cmd, k, col, a, b, c_in, has_res, res);
    if (has_res) begin
      if (typed) begin
        res.acc = want_acc;
        res.bad = want_bad;
      end
      pending_q.push_back(res);
    end
  endtask

  // Hold off input until all results are back, then let a late compute finish
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // hold keeps valid high for a back-to-back write that follows
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                           input bit hold);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    if (idx == REG_INNER_LENGTH) k_len_reg = val;
    else if (idx == REG_NUM_COLS) n_cols_reg = val;
    if (!hold) cfg_valid <= 1'b0;
  endtask

  // Directed rows: typed results only where they are obvious
  dir_row_t dir_tab [NUM_DIR] = '{
    // K below four: c_out is c_in, no memory read
    '{ROW_CFG,  REG_INNER_LENGTH, 9'd0, CMD_LOAD_A, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0,
      1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_UNUSED, 9'd0, CMD_COMPUTE, 8'h00, 8'h00, 8'h00, 8'h00, 32'h7fff_ffff,
      1'b1, 32'h7fff_ffff, 1'b0},
    '{ROW_ITEM, REG_UNUSED, 9'd0, CMD_COMPUTE, 8'h00, 8'hff, 8'h00, 8'h00, 32'h8000_0000,
      1'b1, 32'h8000_0000, 1'b0},
    // bad column: zero result, flag set
    '{ROW_CFG,  REG_NUM_COLS, 9'd1, CMD_LOAD_A, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0,
      1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_UNUSED, 9'd0, CMD_COMPUTE, 8'h00, 8'h01, 8'h00, 8'h00, 32'hdead_beef,
      1'b1, 32'h0, 1'b1},
    '{ROW_ITEM, REG_UNUSED, 9'd0, CMD_COMPUTE, 8'h00, 8'hff, 8'h00, 8'h00, 32'hffff_ffff,
      1'b1, 32'h0, 1'b1},
    '{ROW_ITEM, REG_UNUSED, 9'd0, CMD_COMPUTE, 8'h00, 8'h00, 8'h00, 8'h00, 32'h1234_5678,
      1'b1, 32'h1234_5678, 1'b0},
    '{ROW_CFG,  REG_NUM_COLS, 9'd0, CMD_LOAD_A, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0,
      1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_UNUSED, 9'd0, CMD_COMPUTE, 8'h00, 8'h00, 8'h00, 8'h00, 32'h1,
      1'b1, 32'h0, 1'b1},
    // write to a register index that does not exist
    '{ROW_CFG,  REG_UNUSED, 9'd511, CMD_LOAD_A, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0,
      1'b0, 32'h0, 1'b0},
    '{ROW_CFG,  REG_NUM_COLS, 9'd256, CMD_LOAD_A, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0,
      1'b0, 32'h0, 1'b0},
    '{ROW_CFG,  REG_INNER_LENGTH, 9'd4, CMD_LOAD_A, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0,
      1'b0, 32'h0, 1'b0},
    // extreme operands: A all 255, B all -128
    '{ROW_ITEM, REG_UNUSED, 9'd0, CMD_LOAD_A, 8'h00, 8'h00, 8'hff, 8'h00, 32'h0,
      1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_UNUSED, 9'd0, CMD_LOAD_A, 8'h01, 8'h00, 8'hff, 8'h00, 32'h0,
      1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_UNUSED, 9'd0, CMD_LOAD_A, 8'h02, 8'h00, 8'hff, 8'h00, 32'h0,
      1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_UNUSED, 9'd0, CMD_LOAD_A, 8'h03, 8'h00, 8'hff, 8'h00, 32'h0,
      1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_UNUSED, 9'd0, CMD_LOAD_A, 8'hff, 8'h00, 8'h00, 8'h00, 32'h0,
      1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_UNUSED, 9'd0, CMD_LOAD_B, 8'h00, 8'hff, 8'h00, 8'h80, 32'h0,
      1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_UNUSED, 9'd0, CMD_LOAD_B, 8'h01, 8'hff, 8'h00, 8'h80, 32'h0,
      1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_UNUSED, 9'd0, CMD_LOAD_B, 8'h02, 8'hff, 8'h00, 8'h80, 32'h0,
      1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_UNUSED, 9'd0, CMD_LOAD_B, 8'h03, 8'hff, 8'h00, 8'h80, 32'h0,
      1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_UNUSED, 9'd0, CMD_COMPUTE, 8'h00, 8'hff, 8'h00, 8'h00, 32'h0,
      1'b0, 32'h0, 1'b0},
    // unused command is dropped
    '{ROW_ITEM, REG_UNUSED, 9'd0, CMD_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff, 32'hffff_ffff,
      1'b0, 32'h0, 1'b0},
    // K = 7 rounds down to four terms; c_in near the bottom wraps
    '{ROW_CFG,  REG_INNER_LENGTH, 9'd7, CMD_LOAD_A, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0,
      1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_UNUSED, 9'd0, CMD_COMPUTE, 8'h00, 8'hff, 8'h00, 8'h00, 32'h8000_0000,
      1'b0, 32'h0, 1'b0},
    '{ROW_CFG,  REG_INNER_LENGTH, 9'd3, CMD_LOAD_A, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0,
      1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, REG_UNUSED, 9'd0, CMD_COMPUTE, 8'h00, 8'hff, 8'h00, 8'h00, 32'h0,
      1'b1, 32'h0, 1'b0}
  };

  // Register settings per random phase, extremes and oversized values included
  phase_cfg_t phase_tab [NUM_PHASES] = '{
    '{9'd256, 9'd256}, '{9'd8,  9'd256}, '{9'd511, 9'd2},   '{9'd13, 9'd37},
    '{9'd0,   9'd256}, '{9'd32, 9'd511}, '{9'd1,   9'd0},   '{9'd64, 9'd100},
    '{9'd20,  9'd255}, '{9'd4,  9'd256}
  };

  // Receiver: ready pattern switches between randomly chosen modes
  int unsigned rx_mode = 0, rx_mode_left = 0, rx_hold = 0;

  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= $urandom_range(0, 3);
      rx_mode_left <= $urandom_range(16, 96);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        // long stalls with single-cycle ready pulses
        if (rx_hold == 0) begin
          m_tready <= 1'b1;
          rx_hold  <= $urandom_range(1, 24);
        end else begin
          m_tready <= 1'b0;
          rx_hold  <= rx_hold - 1;
        end
      end
    endcase
  end

  // Result check against the oldest expectation
  always @(posedge clk_i) begin : res_check
    gemm_res_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: expected no result, actual col %0d c_out %h bad_col %b",
                 $time, m_tdata[7:0], m_tdata[39:8], m_tuser[0]);
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (m_tdata[7:0] !== want.col) begin
          $display("%0t: out_col expected %0d actual %0d", $time, want.col, m_tdata[7:0]);
          err_cnt++;
        end
        if (m_tdata[39:8] !== want.acc) begin
          $display("%0t: c_out expected %h actual %h", $time, want.acc, m_tdata[39:8]);
          err_cnt++;
        end
        if (m_tuser[0] !== want.bad) begin
          $display("%0t: bad_col expected %b actual %b", $time, want.bad, m_tuser[0]);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on any channel
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned item_cnt, ph, phase_end, nt, reload_odds, pick, reps;
    logic [7:0]  col;
    phase_cfg_t  pc;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    for (int i = 0; i < NUM_DIR; i++) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        if (i == 0 || dir_tab[i-1].kind != ROW_CFG) settle();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val,
                  (i + 1 < NUM_DIR) && (dir_tab[i+1].kind == ROW_CFG));
      end else begin
        send_item(dir_tab[i].cmd, dir_tab[i].k, dir_tab[i].col, dir_tab[i].a, dir_tab[i].b,
                  dir_tab[i].c_in, dir_tab[i].typed, dir_tab[i].want_acc,
                  dir_tab[i].want_bad);
      end
    end

    // Random phases, each under its own register setting
    item_cnt = 0;
    ph       = 0;
    while (item_cnt < RANDOM_ITEMS) begin
      pc = phase_tab[ph % NUM_PHASES];
      ph++;
      settle();
      if ($urandom_range(0, 1)) begin
        write_reg(REG_INNER_LENGTH, pc.k_len, 1'b1);
        write_reg(REG_NUM_COLS, pc.n_cols, 1'b0);
      end else begin
        write_reg(REG_NUM_COLS, pc.n_cols, 1'b1);
        write_reg(REG_INNER_LENGTH, pc.k_len, 1'b0);
      end
      nt          = terms_used();
      reload_odds = (nt > 32) ? 64 : 4;
      phase_end   = item_cnt + PHASE_ITEMS;

      while (item_cnt < phase_end) begin
        if ($urandom_range(0, 4) != 0) begin
          // Well-formed: pick a column, load its operands, then compute on it
          if (nt > 32) begin
            // long rows: stay on columns 0 and 1 so their loads are reused, with an occasional bad column
            if ($urandom_range(0, 7) == 0 && n_cols_reg < N_MAX)
              col = 8'($urandom_range(n_cols_reg, N_MAX - 1));
            else
              col = ($urandom_range(0, 3) == 0) ? 8'd1 : 8'd0;
          end else begin
            pick = $urandom_range(0, 9);
            if (pick == 0) col = 8'hff;
            else if (pick == 1) col = 8'h00;
            else col = 8'($urandom_range(0, 255));
          end
          if (col < n_cols_reg) begin
            for (int unsigned k = 0; k < nt; k++) begin
              if (!a_wr[k] || $urandom_range(1, reload_odds) == 1) begin
                send_item(CMD_LOAD_A, 8'(k), 8'($urandom()), 8'($urandom()), 8'($urandom()),
                          $urandom(), 1'b0, 32'h0, 1'b0);
                item_cnt++;
              end
            end
            for (int unsigned k = 0; k < nt; k++) begin
              if (!b_wr[k][col] || $urandom_range(1, reload_odds) == 1) begin
                send_item(CMD_LOAD_B, 8'(k), col, 8'($urandom()), 8'($urandom()),
                          $urandom(), 1'b0, 32'h0, 1'b0);
                item_cnt++;
              end
            end
          end
          reps = $urandom_range(1, 3);
          repeat (reps) begin
            send_item(CMD_COMPUTE, 8'($urandom()), col, 8'($urandom()), 8'($urandom()),
                      pick_acc(), 1'b0, 32'h0, 1'b0);
            item_cnt++;
          end
        end else begin
          // Noise: stray loads, dropped commands, computes on any safe column
          col = 8'($urandom_range(0, 255));
          case ($urandom_range(0, 3))
            0: begin
              send_item(CMD_LOAD_A, 8'($urandom()), col, 8'($urandom()), 8'($urandom()),
                        $urandom(), 1'b0, 32'h0, 1'b0);
              item_cnt++;
            end
            1: begin
              send_item(CMD_LOAD_B, 8'($urandom()), col, 8'($urandom()), 8'($urandom()),
                        $urandom(), 1'b0, 32'h0, 1'b0);
              item_cnt++;
            end
            2: send_item(CMD_UNUSED, 8'($urandom()), col, 8'($urandom()), 8'($urandom()),
                         $urandom(), 1'b0, 32'h0, 1'b0);
            default: begin
              if (col >= n_cols_reg || column_loaded(col)) begin
                send_item(CMD_COMPUTE, 8'($urandom()), col, 8'($urandom()), 8'($urandom()),
                          pick_acc(), 1'b0, 32'h0, 1'b0);
                item_cnt++;
              end
            end
          endcase
        end
        // occasional full drain in mid-phase
        if ($urandom_range(0, 39) == 0) settle();
      end
    end

    settle();
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
